// ===== rtl/btk_pkg.sv =====
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types, token codes and slot layout for the binary to kanji token unit.
// ----------------------------------------------------------------------------
package btk_pkg;

  localparam int unsigned VALUE_W    = 30;
  localparam int unsigned TOKEN_W    = 4;
  localparam int unsigned NUM_DIGITS = 9;
  localparam int unsigned NUM_SLOTS  = 17;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned QDEPTH_DEF = 2;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 30'd999999999;

  // reciprocal of ten, exact for any 32-bit dividend with a shift of 35
  localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
  localparam int unsigned RECIP10_SHIFT = 35;

  // token codes
  localparam logic [TOKEN_W-1:0] TOK_ZERO     = 4'd0;
  localparam logic [TOKEN_W-1:0] TOK_TEN      = 4'd10;
  localparam logic [TOKEN_W-1:0] TOK_HUNDRED  = 4'd11;
  localparam logic [TOKEN_W-1:0] TOK_THOUSAND = 4'd12;
  localparam logic [TOKEN_W-1:0] TOK_MAN      = 4'd13;
  localparam logic [TOKEN_W-1:0] TOK_OKU      = 4'd14;

  // emission slots, highest index goes out first
  localparam logic [SLOT_W-1:0] SLOT_D8  = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_OKU = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_D7  = 5'd14;
  localparam logic [SLOT_W-1:0] SLOT_U7  = 5'd13;
  localparam logic [SLOT_W-1:0] SLOT_D6  = 5'd12;
  localparam logic [SLOT_W-1:0] SLOT_U6  = 5'd11;
  localparam logic [SLOT_W-1:0] SLOT_D5  = 5'd10;
  localparam logic [SLOT_W-1:0] SLOT_U5  = 5'd9;
  localparam logic [SLOT_W-1:0] SLOT_D4  = 5'd8;
  localparam logic [SLOT_W-1:0] SLOT_MAN = 5'd7;
  localparam logic [SLOT_W-1:0] SLOT_D3  = 5'd6;
  localparam logic [SLOT_W-1:0] SLOT_U3  = 5'd5;
  localparam logic [SLOT_W-1:0] SLOT_D2  = 5'd4;
  localparam logic [SLOT_W-1:0] SLOT_U2  = 5'd3;
  localparam logic [SLOT_W-1:0] SLOT_D1  = 5'd2;
  localparam logic [SLOT_W-1:0] SLOT_U1  = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_D0  = 5'd0;

  typedef logic [NUM_DIGITS-1:0][3:0] btk_digits_t;

  typedef struct packed {
    btk_digits_t          digits;
    logic [NUM_SLOTS-1:0] mask;
    logic                 err;
  } btk_entry_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } btk_front_e;

  function automatic logic [TOKEN_W-1:0] slot_token(input logic [SLOT_W-1:0] slot,
                                                    input btk_digits_t d);
    logic [TOKEN_W-1:0] tok;
    case (slot)
      SLOT_D8:  tok = d[8];
      SLOT_OKU: tok = TOK_OKU;
      SLOT_D7:  tok = d[7];
      SLOT_U7:  tok = TOK_THOUSAND;
      SLOT_D6:  tok = d[6];
      SLOT_U6:  tok = TOK_HUNDRED;
      SLOT_D5:  tok = d[5];
      SLOT_U5:  tok = TOK_TEN;
      SLOT_D4:  tok = d[4];
      SLOT_MAN: tok = TOK_MAN;
      SLOT_D3:  tok = d[3];
      SLOT_U3:  tok = TOK_THOUSAND;
      SLOT_D2:  tok = d[2];
      SLOT_U2:  tok = TOK_HUNDRED;
      SLOT_D1:  tok = d[1];
      SLOT_U1:  tok = TOK_TEN;
      SLOT_D0:  tok = d[0];
      default:  tok = TOK_ZERO;
    endcase
    return tok;
  endfunction

endpackage

// ===== rtl/btk_front.sv =====
// ----------------------------------------------------------------------------
// btk_front
// Accepts a value, classifies it and splits it into decimal digits, one
// digit per cycle, then pushes the digits and their slot mask to the queue.
// ----------------------------------------------------------------------------
module btk_front import btk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               full_i,
  output logic               push_o,
  output btk_entry_t         entry_o
);

  localparam logic [2:0] CONV_LAST = 3'(NUM_DIGITS - 2);

  btk_front_e state_q, state_d;

  logic [VALUE_W-1:0]   rem_q;
  logic [2:0]           cnt_q;
  btk_digits_t          digits_q;
  logic                 special_q;
  logic                 err_q;

  logic                 is_err;
  logic                 is_zero;
  logic [61:0]          prod;
  logic [26:0]          quo;
  logic [3:0]           tens;
  logic [3:0]           dig;
  logic [NUM_DIGITS-1:0] nz;
  logic [NUM_SLOTS-1:0] mask;

  assign is_err  = value_i > MAX_VALUE;
  assign is_zero = value_i == '0;

  // divide by ten through the reciprocal, remainder needs only the low nibble
  assign prod = 62'(rem_q) * 62'(RECIP10);
  assign quo  = prod[61:RECIP10_SHIFT];
  assign tens = {quo[0], 3'b000} + {quo[2:0], 1'b0};
  assign dig  = rem_q[3:0] - tens;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nz[i] = digits_q[i] != 4'd0;
    end
  end

  always_comb begin
    mask = '0;
    if (special_q) begin
      mask[SLOT_D0] = 1'b1;
    end else begin
      mask[SLOT_D8]  = nz[8];
      mask[SLOT_OKU] = nz[8];
      mask[SLOT_D7]  = nz[7];
      mask[SLOT_U7]  = nz[7];
      mask[SLOT_D6]  = nz[6];
      mask[SLOT_U6]  = nz[6];
      mask[SLOT_D5]  = nz[5];
      mask[SLOT_U5]  = nz[5];
      mask[SLOT_D4]  = nz[4];
      mask[SLOT_MAN] = |nz[7:4];
      mask[SLOT_D3]  = nz[3];
      mask[SLOT_U3]  = nz[3];
      mask[SLOT_D2]  = nz[2];
      mask[SLOT_U2]  = nz[2];
      mask[SLOT_D1]  = nz[1];
      mask[SLOT_U1]  = nz[1];
      mask[SLOT_D0]  = nz[0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (start) begin
          state_d = (is_err || is_zero) ? FR_PUSH : FR_CONV;
        end
      end
      FR_CONV: begin
        if (cnt_q == CONV_LAST) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    busy           = state_q != FR_IDLE;
    push_o         = (state_q == FR_PUSH) && !full_i;
    entry_o.digits = digits_q;
    entry_o.mask   = mask;
    entry_o.err    = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && start) begin
      rem_q     <= value_i;
      cnt_q     <= '0;
      digits_q  <= '0;
      special_q <= is_err || is_zero;
      err_q     <= is_err;
    end else if (state_q == FR_CONV) begin
      digits_q[{1'b0, cnt_q}] <= dig;
      rem_q                   <= VALUE_W'(quo);
      cnt_q                   <= cnt_q + 3'd1;
      if (cnt_q == CONV_LAST) begin
        digits_q[NUM_DIGITS-1] <= quo[3:0];
      end
    end
  end

endmodule

// ===== rtl/btk_queue.sv =====
// ----------------------------------------------------------------------------
// btk_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module btk_queue import btk_pkg::*; #(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  btk_entry_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output btk_entry_t rdata_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  btk_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_FULL;
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/btk_back.sv =====
// ----------------------------------------------------------------------------
// btk_back
// Walks the slot mask of one item from the highest slot down and sends one
// token per cycle, loading a queued next item in the cycle of its final token.
// ----------------------------------------------------------------------------
module btk_back import btk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  btk_entry_t         entry_i,
  output logic               pop_o,
  output logic               result_valid_o,
  output logic [TOKEN_W-1:0] token_o,
  output logic               range_error_o,
  output logic               last_o
);

  logic                 active_q;
  btk_digits_t          digits_q;
  logic [NUM_SLOTS-1:0] mask_q;
  logic                 err_q;

  logic [SLOT_W-1:0]    sel;
  logic [NUM_SLOTS-1:0] rest;
  logic                 done;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (mask_q[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign rest = mask_q & ~(NUM_SLOTS'(1) << sel);
  assign done = rest == '0;

  // take the next item when idle or on the final token of the current one
  assign pop_o = !empty_i && (!active_q || done);

  assign result_valid_o = active_q;
  assign token_o        = slot_token(sel, digits_q);
  assign range_error_o  = err_q;
  assign last_o         = active_q && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (pop_o) begin
      active_q <= 1'b1;
    end else if (done) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digits_q <= entry_i.digits;
      mask_q   <= entry_i.mask;
      err_q    <= entry_i.err;
    end else if (active_q) begin
      mask_q <= rest;
    end
  end

endmodule

// ===== rtl/binary_to_kanji_numeral_tokens_unit.sv =====
// Flow: an accepted value is registered, split into digits one per cycle by the
// divide-by-ten multiplier, pushed to the queue once it has room and loaded by
// the back end; zero and out-of-range values skip the split. A value is spelled
// with 1 to 17 tokens, leaving at one per cycle; the front takes one value at a time.
// The results cannot be stalled; the queue lets a new value enter while tokens go out.
// Reset: rst_ni clears the front state, the queue pointers and the output strobe.
// ----------------------------------------------------------------------------
// binary_to_kanji_numeral_tokens_unit
// Spells a binary integer as a run of formal Japanese numeral token codes.
// ----------------------------------------------------------------------------
module binary_to_kanji_numeral_tokens_unit import btk_pkg::*; #(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  output logic               result_valid_o,
  output logic [TOKEN_W-1:0] token_o,
  output logic               range_error_o,
  output logic               last_o
);

  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  btk_entry_t q_wdata;
  btk_entry_t q_rdata;

  btk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .value_i (value_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (q_wdata)
  );

  btk_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  btk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .entry_i        (q_rdata),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .token_o        (token_o),
    .range_error_o  (range_error_o),
    .last_o         (last_o)
  );

  // an out-of-range result is a single zero token
  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && range_error_o) |-> (last_o && token_o == TOK_ZERO))
    else $error("range error result is not a lone final token");

  // a unit token always follows its nonzero numeral directly
  a_unit_after_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (token_o == TOK_TEN || token_o == TOK_HUNDRED ||
                        token_o == TOK_THOUSAND))
    |-> ($past(result_valid_o) && !$past(last_o) &&
         $past(token_o) != TOK_ZERO && $past(token_o) < TOK_TEN))
    else $error("unit token without a preceding numeral");

  a_token_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (token_o <= TOK_OKU))
    else $error("token code out of range");

endmodule
